/* rtl/lbps_pkg.sv */
`default_nettype none

package lbps_pkg;

  localparam int LED_COUNT     = 4;
  localparam int PATTERN_COUNT = 13;
  localparam int OUT_LEDS      = 4;

  localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_CNT_W = $clog2(LED_COUNT + 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef enum logic [2:0] {
    KIND_OFF     = 3'd0,
    KIND_ON      = 3'd1,
    KIND_CYCLE   = 3'd2,
    KIND_COUNTED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRAP
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  sel;
    logic [3:0]  pos;
    logic [7:0]  ticks;
    logic [7:0]  len;
    logic [7:0]  reps;
    logic        level;
  } led_entry_t;

  // column 0 is the kind, then on/off durations ending in zero
  localparam logic [7:0] BLINK_ROM [16][16] = '{
    '{0: 8'd0, default: 8'd0},
    '{0: 8'd1, default: 8'd0},
    '{0: 8'd2, 1: 8'd5, 2: 8'd25, default: 8'd0},
    '{0: 8'd2, 1: 8'd1, 2: 8'd29, default: 8'd0},
    '{0: 8'd2, 1: 8'd1, 2: 8'd3, 3: 8'd1, 4: 8'd25, default: 8'd0},
    '{0: 8'd2, 1: 8'd3, 2: 8'd27, default: 8'd0},
    '{0: 8'd2, 1: 8'd1, 2: 8'd29, default: 8'd0},
    '{0: 8'd2, 1: 8'd10, 2: 8'd20, default: 8'd0},
    '{0: 8'd4, 1: 8'd1, 2: 8'd10, default: 8'd0},
    '{0: 8'd4, 1: 8'd1, 2: 8'd3, default: 8'd0},
    '{0: 8'd4, 1: 8'd1, 2: 8'd3, 3: 8'd1, 4: 8'd3, default: 8'd0},
    '{0: 8'd4, 1: 8'd1, 2: 8'd3, 3: 8'd1, 4: 8'd3, 5: 8'd1, 6: 8'd3,
      default: 8'd0},
    '{0: 8'd4, 1: 8'd1, 2: 8'd3, 3: 8'd1, 4: 8'd3, 5: 8'd1, 6: 8'd3,
      7: 8'd1, 8: 8'd3, 9: 8'd1, 10: 8'd3, default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0}
  };

  function automatic logic [7:0] rom_step(input logic [3:0] row, input logic [3:0] col);
    return BLINK_ROM[row][col];
  endfunction

  function automatic kind_t rom_kind(input logic [3:0] row);
    return kind_t'(BLINK_ROM[row][0][2:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/lbps_item_if.sv */
`default_nettype none

interface lbps_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] led_index;
  logic [3:0] pattern_number;
  logic [7:0] repeat_count;

  modport source (output valid, opcode, led_index, pattern_number, repeat_count,
                  input ready);
  modport sink (input valid, opcode, led_index, pattern_number, repeat_count,
                output ready);
endinterface

`default_nettype wire

/* rtl/lbps_result_if.sv */
`default_nettype none

interface lbps_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_levels;
  logic [3:0] active_mask;
  logic       ticking;

  modport source (output valid, led_levels, active_mask, ticking, input ready);
  modport sink (input valid, led_levels, active_mask, ticking, output ready);
endinterface

`default_nettype wire

/* rtl/led_blink_pattern_sequencer.sv */
// LED blink pattern sequencer.
// item channel: a transaction is either a tick (opcode 0) or a set-mode
// (opcode 1) that loads one LED with a ROM pattern and a repeat count.
// result channel: one transaction per item, carrying the LED levels, the
// mask of LEDs with a running pattern, and the ticking flag, all taken
// after the item is applied.
// Per-LED state lives in a small synchronous memory with registered read
// data. A set-mode writes its entry directly and answers in the cycle
// after acceptance, as does a tick while stopped. A tick while running
// walks the memory, one read per LED, modifying and writing back each
// entry as its read data returns, then wraps up in the S_WRAP state
// before the result is given.
// One item is in flight at a time; the next is taken once the result has
// been or is being taken.
// Reset stops ticking, marks every entry as cleared (it reads as all zero,
// pattern off) and empties the result register.
// When the receiver stalls the result holds and no new item is accepted.
`default_nettype none

module led_blink_pattern_sequencer (
  input  wire           clk,
  input  wire           rst,
  lbps_item_if.sink     item,
  lbps_result_if.source result
);

  lbps_pkg::state_t     state, state_next;
  lbps_pkg::led_entry_t mem [lbps_pkg::LED_COUNT];
  lbps_pkg::led_entry_t rd_data, cur, nxt, set_entry, wr_data;

  logic [lbps_pkg::LED_COUNT-1:0] entry_valid;
  logic [lbps_pkg::LED_COUNT-1:0] levels;
  logic [lbps_pkg::LED_COUNT-1:0] active;
  logic                           tick_enable;
  logic                           out_valid;
  logic                           rd_ok;
  logic                           rd_pending;
  logic [lbps_pkg::LED_CNT_W-1:0] issue_cnt;
  logic [lbps_pkg::LED_IDX_W-1:0] proc_idx;
  logic [lbps_pkg::LED_IDX_W-1:0] rd_addr;
  logic [lbps_pkg::LED_IDX_W-1:0] set_addr;
  logic [lbps_pkg::LED_IDX_W-1:0] wr_addr;

  logic       out_free;
  logic       accept;
  logic       issue_done;
  logic       rd_issue;
  logic       wrap_fire;
  logic       set_hit;
  logic       start_scan;
  logic       mem_we;
  logic       any_active;
  logic [3:0] set_row;

  assign out_free   = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign issue_done = (issue_cnt == lbps_pkg::LED_CNT_W'(lbps_pkg::LED_COUNT));
  assign rd_addr    = issue_cnt[lbps_pkg::LED_IDX_W-1:0];
  assign set_addr   = lbps_pkg::LED_IDX_W'(item.led_index);
  assign set_hit    = accept && (item.opcode == lbps_pkg::OP_SET) &&
                      (32'(item.led_index) < lbps_pkg::LED_COUNT);
  assign start_scan = accept && (item.opcode == lbps_pkg::OP_TICK) && tick_enable;
  assign any_active = |active;

  always_comb begin
    state_next = state;
    case (state)
      lbps_pkg::S_IDLE: begin
        if (start_scan) state_next = lbps_pkg::S_SCAN;
      end
      lbps_pkg::S_SCAN: begin
        if (issue_done && rd_pending) state_next = lbps_pkg::S_WRAP;
      end
      lbps_pkg::S_WRAP: begin
        if (out_free) state_next = lbps_pkg::S_IDLE;
      end
      default: state_next = lbps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    rd_issue   = 1'b0;
    wrap_fire  = 1'b0;
    case (state)
      lbps_pkg::S_IDLE: item.ready = out_free;
      lbps_pkg::S_SCAN: rd_issue = !issue_done;
      lbps_pkg::S_WRAP: wrap_fire = out_free;
      default: item.ready = 1'b0;
    endcase
  end

  always_comb begin
    set_row = (32'(item.pattern_number) < lbps_pkg::PATTERN_COUNT) ?
              item.pattern_number : 4'd0;
    set_entry       = '0;
    set_entry.kind  = lbps_pkg::rom_kind(set_row);
    set_entry.sel   = set_row;
    set_entry.len   = lbps_pkg::rom_step(set_row, 4'd1);
    set_entry.reps  = (set_entry.kind == lbps_pkg::KIND_COUNTED) ? item.repeat_count : 8'd0;
  end

  // advance one LED by one tick
  always_comb begin
    logic [7:0] t;
    logic [7:0] r;
    cur = rd_ok ? rd_data : '0;
    nxt = cur;
    t   = cur.ticks + 8'd1;
    r   = (cur.reps != 8'd0) ? cur.reps - 8'd1 : cur.reps;
    case (cur.kind)
      lbps_pkg::KIND_OFF: nxt.level = 1'b0;
      lbps_pkg::KIND_ON:  nxt.level = 1'b1;
      default: begin
        if (cur.pos == 4'd0 && cur.ticks == 8'd0) begin
          nxt.level = 1'b1;
          nxt.pos   = 4'd1;
          nxt.len   = lbps_pkg::rom_step(cur.sel, 4'd1);
        end else if (t != cur.len) begin
          nxt.ticks = t;
        end else begin
          nxt.pos   = cur.pos + 4'd1;
          nxt.level = !cur.level;
          nxt.len   = lbps_pkg::rom_step(cur.sel, cur.pos + 4'd1);
          nxt.ticks = 8'd0;
          if (nxt.len == 8'd0) begin
            nxt.pos   = 4'd0;
            nxt.level = 1'b0;
            if (cur.kind == lbps_pkg::KIND_COUNTED) begin
              nxt.reps = r;
              if (r != 8'd0) nxt.ticks = 8'hFF;
              else nxt.kind = lbps_pkg::KIND_OFF;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    mem_we  = set_hit || (state == lbps_pkg::S_SCAN && rd_pending);
    wr_addr = set_hit ? set_addr : proc_idx;
    wr_data = set_hit ? set_entry : nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_issue) rd_data <= mem[rd_addr];
    if (rd_issue) proc_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lbps_pkg::S_IDLE;
      entry_valid <= '0;
      levels      <= '0;
      active      <= '0;
      tick_enable <= 1'b0;
      out_valid   <= 1'b0;
      rd_ok       <= 1'b0;
      rd_pending  <= 1'b0;
      issue_cnt   <= '0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_issue;
      if (rd_issue) begin
        rd_ok     <= entry_valid[rd_addr];
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (start_scan) issue_cnt <= '0;
      if (set_hit) begin
        entry_valid[set_addr] <= 1'b1;
        levels[set_addr]      <= 1'b0;
        active[set_addr]      <= (set_entry.kind != lbps_pkg::KIND_OFF);
        tick_enable           <= 1'b1;
      end
      if (state == lbps_pkg::S_SCAN && rd_pending) begin
        entry_valid[proc_idx] <= 1'b1;
        levels[proc_idx]      <= nxt.level;
        active[proc_idx]      <= (nxt.kind != lbps_pkg::KIND_OFF);
      end
      if (wrap_fire && !any_active) begin
        entry_valid <= '0;
        levels      <= '0;
        active      <= '0;
        tick_enable <= 1'b0;
      end
      if (accept && !start_scan) out_valid <= 1'b1;
      else if (wrap_fire) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    result.valid       = out_valid;
    result.led_levels  = '0;
    result.active_mask = '0;
    result.ticking     = tick_enable;
    for (int i = 0; i < lbps_pkg::OUT_LEDS; i++) begin
      if (i < lbps_pkg::LED_COUNT) begin
        result.led_levels[i]  = levels[i];
        result.active_mask[i] = active[i];
      end
    end
  end

endmodule

`default_nettype wire
